### hw/rtl/i2c_target_register_file_defines.svh
// Assertion macros for the I2C target register file.
`ifndef I2C_TARGET_REGISTER_FILE_DEFINES_SVH
`define I2C_TARGET_REGISTER_FILE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CTRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2ctrf assertion failed");
`define I2CTRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2ctrf assertion failed");
`else
`define I2CTRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2CTRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/i2ctrf_pkg.sv
// Types and constants shared by the I2C target register file modules.
package i2ctrf_pkg;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_ADDR_W     = 4'd1,
      PH_ACK_W      = 4'd2,
      PH_REG        = 4'd3,
      PH_ACK_REG    = 4'd4,
      PH_DATA_FIRST = 4'd5,
      PH_DATA       = 4'd6,
      PH_ACK_DATA   = 4'd7,
      PH_ADDR_R     = 4'd8,
      PH_ACK_R      = 4'd9,
      PH_TX         = 4'd10,
      PH_TX_ACK     = 4'd11
   } phase_type;

   localparam logic CSR_OWN_ADDRESS  = 1'b0;
   localparam logic CSR_IDLE_TIMEOUT = 1'b1;

   localparam logic [6:0]  OWN_ADDRESS_RESET  = 7'd80;
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd2000;
   localparam logic [7:0]  EMPTY_READ_BYTE    = 8'hFF;

   typedef struct packed {
      logic       en;
      logic [7:0] index;
      logic [7:0] data;
   } store_wr_type;

endpackage

### hw/rtl/i2ctrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2ctrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/i2ctrf_store.sv
// Register store: RAM plus per-entry valid bits and write-to-read forwarding.
module i2ctrf_store #(
   parameter int REG_COUNT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  i2ctrf_pkg::store_wr_type wr,
   input  logic [7:0]               rd_index,
   output logic [7:0]               rd_data
);
   import i2ctrf_pkg::*;

   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic                 vld_rd_ff;
   logic                 fwd_hit_ff;
   logic                 fwd_hit_in;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           ram_q;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;

   assign wr_addr = wr.index[AW-1:0];
   assign rd_addr = rd_index[AW-1:0];

   i2ctrf_ram #(
      .WIDTH (8),
      .DEPTH (REG_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // a write in the same cycle as the read of that entry wins
   assign fwd_hit_in = wr.en && (wr.index == rd_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         vld_rd_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         vld_rd_ff  <= valid_ff[rd_addr];
         fwd_hit_ff <= fwd_hit_in;
      end
      fwd_data_ff <= wr.data;
   end

   // never-written entries read as zero
   assign rd_data = fwd_hit_ff ? fwd_data_ff : (vld_rd_ff ? ram_q : 8'd0);

endmodule

### hw/rtl/i2c_target_register_file.sv
// I2C target with a register file and auto-incrementing register pointer.
//
// req_ carries one sampled SCL/SDA pair per word; rsp_ returns exactly one word
// per accepted sample: SDA pull-down, write strobe with index and value, and
// the busy flag, all taken after the sample has been applied.
// Throughput is one sample per cycle while the output is not stalled. The result
// word of a sample sits in the output register from the cycle after acceptance.
// The register store lives in a RAM with registered read. Its read address
// follows the register pointer every cycle, so the byte to be sent is ready
// when an SCL fall loads the transmit shifter; same-entry writes are forwarded.
// When rsp_stall is high with a word valid, the word holds and req_stall rises,
// so samples wait upstream; no sample is dropped or repeated.
// Reset (synchronous, active high) returns the bus logic to idle, clears the
// pointer and the timeout counter, restores own_address 80 and idle_timeout
// 2000, and marks every register as zero through per-entry valid bits, so no
// clearing pass is needed and samples are taken from the first cycle on.
// csr_ writes set own_address (index 0) and idle_timeout (index 1).
`include "i2c_target_register_file_defines.svh"

module i2c_target_register_file #(
   parameter int REG_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_scl_level,
   input  logic        req_sda_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sda_pull_low,
   output logic        rsp_write_strobe,
   output logic [7:0]  rsp_write_index,
   output logic [7:0]  rsp_write_value,
   output logic        rsp_busy_res,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import i2ctrf_pkg::*;

   localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);
   localparam logic [8:0] REG_LAST  = 9'(REG_COUNT - 1);

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  pointer_ff, pointer_in;
   logic [15:0] steady_ff, steady_in;
   logic        last_scl_ff, last_sda_ff;
   logic [6:0]  own_address_ff;
   logic [15:0] idle_timeout_ff;

   logic        rsp_valid_ff;
   logic        pull_ff, pull_in;
   logic        strobe_ff, strobe_in;
   logic [7:0]  widx_ff, widx_in;
   logic [7:0]  wval_ff, wval_in;
   logic        busy_ff, busy_in;

   logic        req_fire;
   logic        rise, fall, high_both, start, stop;
   logic [7:0]  shift_take;
   logic [3:0]  count_inc;
   logic        byte_done;
   logic        ptr_in_range, ptr_at_last;
   logic [7:0]  store_q, read_byte;
   logic [7:0]  rd_index;
   store_wr_type store_wr;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign rise      = !last_scl_ff && req_scl_level;
   assign fall      = last_scl_ff && !req_scl_level;
   assign high_both = last_scl_ff && req_scl_level;
   assign start     = high_both && last_sda_ff && !req_sda_level;
   assign stop      = high_both && !last_sda_ff && req_sda_level;

   assign shift_take   = {shift_ff[6:0], req_sda_level};
   assign count_inc    = bit_count_ff + 4'd1;
   assign byte_done    = count_inc >= 4'd8;
   assign ptr_in_range = {1'b0, pointer_ff} < REG_LIMIT;
   assign ptr_at_last  = {1'b0, pointer_ff} >= REG_LAST;
   assign read_byte    = ptr_in_range ? store_q : EMPTY_READ_BYTE;

   // one bus sample: next state and result word
   always_comb begin
      logic timed_out;
      timed_out    = 1'b0;
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      pointer_in   = pointer_ff;
      steady_in    = steady_ff;
      strobe_in    = 1'b0;
      widx_in      = 8'd0;
      wval_in      = 8'd0;

      if (phase_ff != PH_IDLE) begin
         if (high_both && (req_sda_level == last_sda_ff)) begin
            if (steady_ff >= idle_timeout_ff) begin
               timed_out = 1'b1;
            end else begin
               steady_in = steady_ff + 16'd1;
            end
         end else begin
            steady_in = 16'd0;
         end
      end

      if (timed_out || stop) begin
         phase_in     = PH_IDLE;
         bit_count_in = 4'd0;
         shift_in     = 8'd0;
         steady_in    = 16'd0;
      end else if (start) begin
         phase_in     = (phase_ff == PH_DATA_FIRST) ? PH_ADDR_R : PH_ADDR_W;
         bit_count_in = 4'd0;
         shift_in     = 8'd0;
         steady_in    = 16'd0;
      end else begin
         case (phase_ff)
            PH_ADDR_W, PH_ADDR_R: begin
               if (rise) begin
                  shift_in     = shift_take;
                  bit_count_in = count_inc;
                  if (byte_done) begin
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                     if ((shift_take[7:1] == own_address_ff) &&
                         (shift_take[0] == (phase_ff == PH_ADDR_R))) begin
                        phase_in = (phase_ff == PH_ADDR_R) ? PH_ACK_R : PH_ACK_W;
                     end else begin
                        phase_in  = PH_IDLE;
                        steady_in = 16'd0;
                     end
                  end
               end
            end
            PH_REG: begin
               if (rise) begin
                  shift_in     = shift_take;
                  bit_count_in = count_inc;
                  if (byte_done) begin
                     pointer_in   = shift_take;
                     phase_in     = PH_ACK_REG;
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                  end
               end
            end
            PH_DATA_FIRST, PH_DATA: begin
               if (rise) begin
                  shift_in     = shift_take;
                  bit_count_in = count_inc;
                  if (byte_done) begin
                     if (ptr_in_range) begin
                        strobe_in = 1'b1;
                        widx_in   = pointer_ff;
                        wval_in   = shift_take;
                     end
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                     if (ptr_at_last) begin
                        phase_in  = PH_IDLE;
                        steady_in = 16'd0;
                     end else begin
                        pointer_in = pointer_ff + 8'd1;
                        phase_in   = PH_ACK_DATA;
                     end
                  end
               end
            end
            PH_ACK_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_R: begin
               // first fall starts driving the ACK, second fall releases it
               if (fall) begin
                  if (bit_count_ff == 4'd0) begin
                     bit_count_in = 4'd1;
                  end else begin
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                     case (phase_ff)
                        PH_ACK_W:    phase_in = PH_REG;
                        PH_ACK_REG:  phase_in = PH_DATA_FIRST;
                        PH_ACK_DATA: phase_in = PH_DATA;
                        default: begin
                           phase_in = PH_TX;
                           shift_in = read_byte;
                        end
                     endcase
                  end
               end
            end
            PH_TX: begin
               if (rise) begin
                  bit_count_in = count_inc;
               end else if (fall && (bit_count_ff != 4'd0)) begin
                  if (bit_count_ff >= 4'd8) begin
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                     if (ptr_at_last) begin
                        phase_in  = PH_IDLE;
                        steady_in = 16'd0;
                     end else begin
                        pointer_in = pointer_ff + 8'd1;
                        phase_in   = PH_TX_ACK;
                     end
                  end else begin
                     shift_in = {shift_ff[6:0], 1'b0};
                  end
               end
            end
            PH_TX_ACK: begin
               if (rise && (bit_count_ff == 4'd0)) begin
                  if (req_sda_level) begin
                     phase_in  = PH_IDLE;
                     shift_in  = 8'd0;
                     steady_in = 16'd0;
                  end else begin
                     bit_count_in = 4'd1;
                  end
               end else if (fall && (bit_count_ff == 4'd1)) begin
                  phase_in     = PH_TX;
                  bit_count_in = 4'd0;
                  shift_in     = read_byte;
               end
            end
            PH_IDLE: begin
            end
            default: begin
               phase_in     = PH_IDLE;
               bit_count_in = 4'd0;
               shift_in     = 8'd0;
               steady_in    = 16'd0;
            end
         endcase
      end

      pull_in = 1'b0;
      if (((phase_in == PH_ACK_W) || (phase_in == PH_ACK_REG) ||
           (phase_in == PH_ACK_DATA) || (phase_in == PH_ACK_R)) &&
          (bit_count_in == 4'd1)) begin
         pull_in = 1'b1;
      end else if ((phase_in == PH_TX) && !shift_in[7]) begin
         pull_in = 1'b1;
      end
      busy_in = (phase_in != PH_IDLE) && (phase_in != PH_ADDR_W);
   end

   // read address tracks the pointer the next sample will see
   assign rd_index = req_fire ? pointer_in : pointer_ff;

   assign store_wr.en    = req_fire && strobe_in;
   assign store_wr.index = widx_in;
   assign store_wr.data  = wval_in;

   i2ctrf_store #(
      .REG_COUNT (REG_COUNT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (store_wr),
      .rd_index (rd_index),
      .rd_data  (store_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         pointer_ff   <= 8'd0;
         steady_ff    <= 16'd0;
         last_scl_ff  <= 1'b1;
         last_sda_ff  <= 1'b1;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         pointer_ff   <= pointer_in;
         steady_ff    <= steady_in;
         last_scl_ff  <= req_scl_level;
         last_sda_ff  <= req_sda_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= OWN_ADDRESS_RESET;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OWN_ADDRESS:  own_address_ff  <= csr_write_data[6:0];
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_fire || (rsp_valid_ff && rsp_stall);
      end
      if (req_fire) begin
         pull_ff   <= pull_in;
         strobe_ff <= strobe_in;
         widx_ff   <= widx_in;
         wval_ff   <= wval_in;
         busy_ff   <= busy_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sda_pull_low = pull_ff;
   assign rsp_write_strobe = strobe_ff;
   assign rsp_write_index  = widx_ff;
   assign rsp_write_value  = wval_ff;
   assign rsp_busy_res     = busy_ff;

   `I2CTRF_ASSERT_IMPLY(a_idle_clean, clock, reset, phase_ff == PH_IDLE,
      (bit_count_ff == 4'd0) && (shift_ff == 8'd0))
   `I2CTRF_ASSERT_IMPLY(a_tx_count, clock, reset, phase_ff == PH_TX, bit_count_ff <= 4'd8)
   `I2CTRF_ASSERT_IMPLY(a_strobe_range, clock, reset, rsp_valid_ff && strobe_ff,
      {1'b0, widx_ff} < REG_LIMIT)
   `I2CTRF_ASSERT_NEXT(a_write_fwd, clock, reset, store_wr.en && (rd_index == store_wr.index),
      store_q == $past(store_wr.data))

endmodule

### tb/sv/testbench.sv
// Self-checking bench for the I2C target register file: bus traffic in, predicted words out.
module testbench;
   import i2ctrf_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned PHASE_SAMPLES  = 45;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned LONG_HOLD      = 120;
   localparam logic [7:0]  LAST_INDEX     = 8'd255;

   typedef struct packed {
      logic       sda_pull_low;
      logic       write_strobe;
      logic [7:0] write_index;
      logic [7:0] write_value;
      logic       busy;
   } target_word_type;

   // Tracks the target's bus state and register store, one sampled line pair at a time.
   class i2c_target_tracker;
      logic [6:0]      own_address;
      logic [15:0]     idle_timeout;
      phase_type       phase;
      logic [3:0]      bit_count;
      logic [7:0]      shift_byte;
      logic [7:0]      reg_pointer;
      logic [15:0]     steady_ticks;
      logic            last_scl;
      logic            last_sda;
      logic [7:0]      store [256];
      logic            pull_now;
      target_word_type expected_words [$];
      int unsigned     mismatch_count;
      int unsigned     word_count;

      function new();
         own_address = OWN_ADDRESS_RESET;
         idle_timeout = IDLE_TIMEOUT_RESET;
         phase = PH_IDLE;
         bit_count = 4'd0;
         shift_byte = 8'd0;
         reg_pointer = 8'd0;
         steady_ticks = 16'd0;
         last_scl = 1'b1;
         last_sda = 1'b1;
         foreach (store[i]) store[i] = 8'h00;
         pull_now = 1'b0;
         mismatch_count = 0;
         word_count = 0;
      endfunction

      function void configure(logic idx, logic [15:0] data);
         if (idx == CSR_OWN_ADDRESS)
            own_address = data[6:0];
         else
            idle_timeout = data;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void go_idle();
         phase = PH_IDLE;
         bit_count = 4'd0;
         shift_byte = 8'd0;
         steady_ticks = 16'd0;
      endfunction

      function void enter(phase_type next_phase);
         phase = next_phase;
         bit_count = 4'd0;
         shift_byte = 8'd0;
      endfunction

      // Shifts in one bit MSB first; true once the byte is complete.
      function bit take_bit(logic sda);
         shift_byte = {shift_byte[6:0], sda};
         bit_count = bit_count + 4'd1;
         return bit_count >= 4'd8;
      endfunction

      function void take_sample(logic scl, logic sda);
         logic rise, fall, high_both, start, stop, timed_out;
         logic strobe;
         logic [7:0] widx, wval;
         target_word_type word;
         rise = !last_scl && scl;
         fall = last_scl && !scl;
         high_both = last_scl && scl;
         start = high_both && last_sda && !sda;
         stop = high_both && !last_sda && sda;
         strobe = 1'b0;
         widx = 8'd0;
         wval = 8'd0;
         timed_out = 1'b0;

         if (phase != PH_IDLE) begin
            if (high_both && sda == last_sda) begin
               if (steady_ticks >= idle_timeout)
                  timed_out = 1'b1;
               else
                  steady_ticks = steady_ticks + 16'd1;
            end else begin
               steady_ticks = 16'd0;
            end
         end

         if (timed_out || stop) begin
            go_idle();
         end else if (start) begin
            // repeated start right after the pointer byte turns the transfer into a read
            if (phase == PH_DATA_FIRST)
               enter(PH_ADDR_R);
            else
               enter(PH_ADDR_W);
            steady_ticks = 16'd0;
         end else begin
            case (phase)
               PH_ADDR_W, PH_ADDR_R: begin
                  if (rise) begin
                     if (take_bit(sda)) begin
                        if (shift_byte[7:1] != own_address)
                           go_idle();
                        else if (phase == PH_ADDR_R && shift_byte[0])
                           enter(PH_ACK_R);
                        else if (phase == PH_ADDR_W && !shift_byte[0])
                           enter(PH_ACK_W);
                        else
                           go_idle();
                     end
                  end
               end
               PH_REG: begin
                  if (rise) begin
                     if (take_bit(sda)) begin
                        reg_pointer = shift_byte;
                        enter(PH_ACK_REG);
                     end
                  end
               end
               PH_DATA_FIRST, PH_DATA: begin
                  if (rise) begin
                     if (take_bit(sda)) begin
                        store[reg_pointer] = shift_byte;
                        strobe = 1'b1;
                        widx = reg_pointer;
                        wval = shift_byte;
                        if (reg_pointer == LAST_INDEX) begin
                           go_idle();
                        end else begin
                           reg_pointer = reg_pointer + 8'd1;
                           enter(PH_ACK_DATA);
                        end
                     end
                  end
               end
               PH_ACK_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_R: begin
                  // first fall starts the ACK, second fall ends it
                  if (fall) begin
                     if (bit_count == 4'd0) begin
                        bit_count = 4'd1;
                     end else if (phase == PH_ACK_W) begin
                        enter(PH_REG);
                     end else if (phase == PH_ACK_REG) begin
                        enter(PH_DATA_FIRST);
                     end else if (phase == PH_ACK_DATA) begin
                        enter(PH_DATA);
                     end else begin
                        enter(PH_TX);
                        shift_byte = store[reg_pointer];
                     end
                  end
               end
               PH_TX: begin
                  if (rise) begin
                     bit_count = bit_count + 4'd1;
                  end else if (fall && bit_count != 4'd0) begin
                     if (bit_count >= 4'd8) begin
                        if (reg_pointer == LAST_INDEX) begin
                           go_idle();
                        end else begin
                           reg_pointer = reg_pointer + 8'd1;
                           enter(PH_TX_ACK);
                        end
                     end else begin
                        shift_byte = {shift_byte[6:0], 1'b0};
                     end
                  end
               end
               PH_TX_ACK: begin
                  if (rise && bit_count == 4'd0) begin
                     if (sda)
                        go_idle();
                     else
                        bit_count = 4'd1;
                  end else if (fall && bit_count == 4'd1) begin
                     enter(PH_TX);
                     shift_byte = store[reg_pointer];
                  end
               end
               PH_IDLE: ;
               default: go_idle();
            endcase
         end

         last_scl = scl;
         last_sda = sda;

         word.sda_pull_low = ((phase == PH_ACK_W || phase == PH_ACK_REG ||
                               phase == PH_ACK_DATA || phase == PH_ACK_R) &&
                              bit_count == 4'd1) ||
                             (phase == PH_TX && !shift_byte[7]);
         word.write_strobe = strobe;
         word.write_index = widx;
         word.write_value = wval;
         word.busy = phase != PH_IDLE && phase != PH_ADDR_W;
         pull_now = word.sda_pull_low;
         expected_words.push_back(word);
      endfunction

      function void check_word(logic pull, logic strobe, logic [7:0] index,
                               logic [7:0] value, logic busy);
         target_word_type want;
         word_count++;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("word %0d with none expected: pull %b strobe %b index %h value %h busy %b",
                        word_count, pull, strobe, index, value, busy);
            return;
         end
         want = expected_words.pop_front();
         if (pull !== want.sda_pull_low || strobe !== want.write_strobe ||
             index !== want.write_index || value !== want.write_value ||
             busy !== want.busy) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("word %0d expected: pull %b strobe %b index %h value %h busy %b",
                        word_count, want.sda_pull_low, want.write_strobe,
                        want.write_index, want.write_value, want.busy);
               $display("word %0d actual:   pull %b strobe %b index %h value %h busy %b",
                        word_count, pull, strobe, index, value, busy);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_scl_level;
   logic        req_sda_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_sda_pull_low;
   logic        rsp_write_strobe;
   logic [7:0]  rsp_write_index;
   logic [7:0]  rsp_write_value;
   logic        rsp_busy_res;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   i2c_target_tracker tracker = new();
   int unsigned send_gap_max = 14;
   int unsigned recv_stall_max = 14;
   int unsigned samples_sent = 0;
   int unsigned idle_cycles = 0;
   bit          long_hold_req = 1'b0;

   i2c_target_register_file i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scl_level    (req_scl_level),
      .req_sda_level    (req_sda_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_write_strobe (rsp_write_strobe),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_value  (rsp_write_value),
      .rsp_busy_res     (rsp_busy_res),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sends one sampled line pair; called at a falling edge, returns at one.
   task automatic put_sample(input logic scl, input logic sda);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_scl_level <= scl;
      req_sda_level <= sda;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(scl, sda);
      samples_sent++;
      @(negedge clock);
   endtask

   // Controller drive on the wired-AND data line: the target's pull wins.
   task automatic put_line(input logic scl, input logic ctrl_sda);
      put_sample(scl, ctrl_sda & ~tracker.pull_now);
   endtask

   task automatic bus_bit(input logic b);
      repeat ($urandom_range(1, 2)) put_line(1'b0, b);
      repeat ($urandom_range(1, 2)) put_line(1'b1, b);
   endtask

   task automatic bus_byte(input logic [7:0] value);
      for (int i = 7; i >= 0; i--)
         bus_bit(value[i]);
   endtask

   task automatic bus_start();
      repeat ($urandom_range(1, 2)) put_line(1'b0, 1'b1);
      repeat ($urandom_range(1, 2)) put_line(1'b1, 1'b1);
      put_line(1'b1, 1'b0);
   endtask

   task automatic bus_stop();
      repeat ($urandom_range(1, 2)) put_line(1'b0, 1'b0);
      repeat ($urandom_range(1, 2)) put_line(1'b1, 1'b0);
      put_line(1'b1, 1'b1);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Bias toward the top of the store so transfers run off the last register.
   function automatic logic [7:0] pick_pointer();
      if ($urandom_range(0, 2) == 0)
         return 8'($urandom_range(250, 255));
      return 8'($urandom);
   endfunction

   task automatic write_head(input logic [6:0] addr, input logic [7:0] ptr);
      bus_start();
      bus_byte({addr, 1'b0});
      bus_bit(1'b1);
      bus_byte(ptr);
      bus_bit(1'b1);
   endtask

   task automatic write_transfer(input logic [6:0] addr, input logic [7:0] ptr,
                                 input int unsigned count);
      write_head(addr, ptr);
      repeat (count) begin
         bus_byte(pick_byte());
         bus_bit(1'b1);
      end
      bus_stop();
   endtask

   task automatic read_transfer(input logic [6:0] addr, input logic [7:0] ptr,
                                input int unsigned count);
      write_head(addr, ptr);
      bus_start();
      bus_byte({addr, 1'b1});
      bus_bit(1'b1);
      for (int unsigned i = 0; i < count; i++) begin
         repeat (8) bus_bit(1'b1);
         bus_bit(i + 1 < count ? 1'b0 : 1'b1);
      end
      bus_stop();
   endtask

   task automatic wrong_direction(input logic [6:0] addr);
      bus_start();
      bus_byte({addr, 1'b1});
      bus_bit(1'b1);
      bus_stop();
   endtask

   // Lines frozen with SCL high during the pointer ACK until the target gives up.
   task automatic timeout_transfer(input logic [6:0] addr);
      write_head(addr, pick_pointer());
      repeat (int'(tracker.idle_timeout) + 3) put_line(1'b1, 1'b1);
      bus_stop();
   endtask

   // Stops offering words until every expected word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.configure(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_target(input logic [6:0] addr, input logic [15:0] timeout);
      wait_drained();
      write_csr(CSR_OWN_ADDRESS, {9'($urandom), addr});
      write_csr(CSR_IDLE_TIMEOUT, timeout);
   endtask

   task automatic random_traffic(input int unsigned sample_goal);
      int unsigned stop_at;
      int unsigned count;
      logic [6:0]  addr;
      stop_at = samples_sent + sample_goal;
      while (samples_sent < stop_at) begin
         send_gap_max = $urandom_range(0, 1) ? 14 : 0;
         recv_stall_max = $urandom_range(0, 1) ? 14 : 0;
         addr = ($urandom_range(0, 4) != 0) ? tracker.own_address : 7'($urandom);
         count = $urandom_range(0, 4);
         case ($urandom_range(0, 11))
            0, 1, 2, 3: write_transfer(addr, pick_pointer(), count);
            4, 5, 6: read_transfer(addr, pick_pointer(), count + 1);
            7: wrong_direction(addr);
            8, 9: begin
               // cut short by a stop or a fresh start mid-byte
               write_head(addr, pick_pointer());
               repeat ($urandom_range(1, 12)) bus_bit(1'($urandom));
               if ($urandom_range(0, 1))
                  bus_stop();
               else
                  write_transfer(addr, pick_pointer(), count);
            end
            10: begin
               if (tracker.idle_timeout <= 16'd40)
                  timeout_transfer(addr);
               else
                  repeat ($urandom_range(4, 20)) put_sample(1'($urandom), 1'($urandom));
            end
            default: repeat ($urandom_range(4, 20)) put_sample(1'($urandom), 1'($urandom));
         endcase
         if ($urandom_range(0, 14) == 0)
            wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_scl_level = 1'b1;
      req_sda_level = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_OWN_ADDRESS;
      csr_write_data = 16'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // byte extremes, then a start in mid write that opens a new write
      write_head(OWN_ADDRESS_RESET, 8'h00);
      bus_byte(8'h00);
      bus_bit(1'b1);
      bus_byte(8'hFF);
      bus_bit(1'b1);
      write_transfer(OWN_ADDRESS_RESET, 8'h02, 1);
      read_transfer(OWN_ADDRESS_RESET, 8'h00, 3);
      write_transfer(OWN_ADDRESS_RESET ^ 7'h01, 8'h10, 1);
      wrong_direction(OWN_ADDRESS_RESET);
      // stop in the middle of a data byte
      write_head(OWN_ADDRESS_RESET, 8'h40);
      repeat (4) bus_bit(1'b0);
      bus_stop();
      write_transfer(OWN_ADDRESS_RESET, 8'hFE, 3);
      read_transfer(OWN_ADDRESS_RESET, 8'hFD, 4);

      set_target(7'd0, 16'd1);
      timeout_transfer(7'd0);
      random_traffic(PHASE_SAMPLES);

      set_target(7'd127, 16'd65535);
      long_hold_req = 1'b1;
      random_traffic(PHASE_SAMPLES);

      set_target(7'($urandom), 16'($urandom_range(2, 40)));
      random_traffic(PHASE_SAMPLES);

      set_target(OWN_ADDRESS_RESET, IDLE_TIMEOUT_RESET);
      random_traffic(PHASE_SAMPLES);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side: random stall before each word, one long hold on request.
   initial begin : receiver
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, recv_stall_max);
         if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(rsp_sda_pull_low, rsp_write_strobe, rsp_write_index,
                            rsp_write_value, rsp_busy_res);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
